>>> src/phc_pkg.sv
// phc_pkg: widths, register codes and reset values shared by the clearance pipeline
// no dependencies; imported by the divider, square root and top level modules
package phc_pkg;

    localparam int FRAC_BITS = 16;

    // configuration port
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BODY_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEAD_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF_LENGTH = 2'd2;
    localparam logic [CFG_W-1:0] BODY_RADIUS_RST = 20'd13107;
    localparam logic [CFG_W-1:0] HEAD_RADIUS_RST = 20'd19661;
    localparam logic [CFG_W-1:0] HALF_LENGTH_RST = 20'd65536;

    // datapath widths
    localparam int PT_W    = 32;
    localparam int AX_W    = 18;
    localparam int HLP_W   = CFG_W + AX_W;
    localparam int OFF_W   = 21;
    localparam int P1_W    = 33;
    localparam int DMAG_W  = OFF_W + 1;
    localparam int E_W     = 34;
    localparam int EMAG_W  = 33;
    localparam int HN_W    = 33;
    localparam int HMAG_W  = 33;
    localparam int PROD_W  = EMAG_W + DMAG_W;
    localparam int NUM_W   = PROD_W + 3;
    localparam int SQD_W   = 2 * DMAG_W;
    localparam int LEN_W   = SQD_W + 2;
    localparam int NSQ_W   = 2 * HMAG_W;
    localparam int T_W     = 32;
    localparam int SMUL_W  = DMAG_W + T_W;
    localparam int QD_W    = 34;
    localparam int QMAG_W  = 33;
    localparam int QSQ_W   = 2 * QMAG_W;

    // pipelined divider and square root
    localparam int DIV_STEPS = T_W;
    localparam int SQ_W      = 68;
    localparam int SQ_STEPS  = SQ_W / 2;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int REM_W     = ROOT_W + 2;

    // clearance and saturation
    localparam int CLR_W = ROOT_W + 2;
    localparam logic signed [CLR_W-1:0] SAT_HI = CLR_W'(32'sh7FFF_FFFF);
    localparam logic signed [CLR_W-1:0] SAT_LO = CLR_W'(32'sh8000_0000);

endpackage

>>> src/phc_div_pipe.sv
// phc_div_pipe: restoring divider, one quotient bit per stage, fraction quotient num/den
// depends on phc_pkg; all stages advance together on en
module phc_div_pipe (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [phc_pkg::LEN_W-1:0]   num_i,
    input  logic [phc_pkg::LEN_W-1:0]   den_i,
    output logic [phc_pkg::T_W-1:0]     quo_o
);
    import phc_pkg::*;

    logic [LEN_W-1:0] rem_reg [DIV_STEPS];
    logic [LEN_W-1:0] den_reg [DIV_STEPS];
    logic [T_W-1:0]   quo_reg [DIV_STEPS];
    logic [LEN_W-1:0] rem_next [DIV_STEPS];
    logic [T_W-1:0]   quo_next [DIV_STEPS];
    logic [LEN_W-1:0] den_in [DIV_STEPS];
    logic [LEN_W-1:0] rem_in [DIV_STEPS];
    logic [T_W-1:0]   quo_in [DIV_STEPS];
    logic [LEN_W:0]   rem_sh [DIV_STEPS];
    logic [LEN_W:0]   rem_sub [DIV_STEPS];

    // one compare and subtract per stage
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                rem_in[k] = num_i;
                den_in[k] = den_i;
                quo_in[k] = '0;
            end else begin
                rem_in[k] = rem_reg[k-1];
                den_in[k] = den_reg[k-1];
                quo_in[k] = quo_reg[k-1];
            end
            rem_sh[k]  = {rem_in[k], 1'b0};
            rem_sub[k] = rem_sh[k] - {1'b0, den_in[k]};
            if (rem_sh[k] >= {1'b0, den_in[k]}) begin
                rem_next[k] = rem_sub[k][LEN_W-1:0];
                quo_next[k] = {quo_in[k][T_W-2:0], 1'b1};
            end else begin
                rem_next[k] = rem_sh[k][LEN_W-1:0];
                quo_next[k] = {quo_in[k][T_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo_o = quo_reg[DIV_STEPS-1];

endmodule

>>> src/phc_sqrt_pipe.sv
// phc_sqrt_pipe: digit by digit integer square root, one root bit per stage
// depends on phc_pkg; all stages advance together on en
module phc_sqrt_pipe (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [phc_pkg::SQ_W-1:0]    rad_i,
    output logic [phc_pkg::ROOT_W-1:0]  root_o
);
    import phc_pkg::*;

    logic [REM_W-1:0]  rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0] root_reg [SQ_STEPS];
    logic [SQ_W-1:0]   rad_reg  [SQ_STEPS];
    logic [REM_W-1:0]  rem_next [SQ_STEPS];
    logic [ROOT_W-1:0] root_next [SQ_STEPS];
    logic [REM_W-1:0]  rem_in [SQ_STEPS];
    logic [ROOT_W-1:0] root_in [SQ_STEPS];
    logic [SQ_W-1:0]   rad_in [SQ_STEPS];
    logic [REM_W+1:0]  rem2 [SQ_STEPS];
    logic [REM_W+1:0]  trial [SQ_STEPS];
    logic [REM_W+1:0]  rem_sub [SQ_STEPS];

    // bring down two radicand bits, try root*4+1
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                rem_in[k]  = '0;
                root_in[k] = '0;
                rad_in[k]  = rad_i;
            end else begin
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
                rad_in[k]  = rad_reg[k-1];
            end
            rem2[k]    = {rem_in[k], rad_in[k][SQ_W-1 -: 2]};
            trial[k]   = (REM_W+2)'({root_in[k], 2'b01});
            rem_sub[k] = rem2[k] - trial[k];
            if (rem2[k] >= trial[k]) begin
                rem_next[k]  = rem_sub[k][REM_W-1:0];
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem2[k][REM_W-1:0];
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= {rad_in[k][SQ_W-3:0], 2'b00};
            end
        end
    end

    assign root_o = root_reg[SQ_STEPS-1];

endmodule

>>> src/point_to_human_clearance_unit.sv
// point_to_human_clearance_unit: clearance from a query point to a torso capsule and head sphere
// one transaction per cycle sustained while the output register is free or being taken by m_ready
// the whole pipeline freezes while a result waits on m_ready; depth set by the 32 stage
// divider and the 34 stage square root
// reset clears all valid bits and loads default radii and half length
// depends on phc_pkg, phc_div_pipe and phc_sqrt_pipe
module point_to_human_clearance_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [phc_pkg::PT_W-1:0]     s_point_x,
    input  logic signed [phc_pkg::PT_W-1:0]     s_point_y,
    input  logic signed [phc_pkg::PT_W-1:0]     s_point_z,
    input  logic signed [phc_pkg::PT_W-1:0]     s_torso_x,
    input  logic signed [phc_pkg::PT_W-1:0]     s_torso_y,
    input  logic signed [phc_pkg::PT_W-1:0]     s_torso_z,
    input  logic signed [phc_pkg::AX_W-1:0]     s_axis_x,
    input  logic signed [phc_pkg::AX_W-1:0]     s_axis_y,
    input  logic signed [phc_pkg::AX_W-1:0]     s_axis_z,
    input  logic signed [phc_pkg::PT_W-1:0]     s_neck_x,
    input  logic signed [phc_pkg::PT_W-1:0]     s_neck_y,
    input  logic signed [phc_pkg::PT_W-1:0]     s_neck_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [phc_pkg::PT_W-1:0]     m_clearance,
    output logic                                m_head_nearest,
    output logic signed [phc_pkg::PT_W-1:0]     m_nearest_x,
    output logic signed [phc_pkg::PT_W-1:0]     m_nearest_y,
    output logic signed [phc_pkg::PT_W-1:0]     m_nearest_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [phc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [phc_pkg::CFG_W-1:0]           cfg_data
);
    import phc_pkg::*;

    typedef struct packed {
        logic [2:0][PT_W-1:0]   pt;
        logic [2:0][PT_W-1:0]   nk;
        logic [2:0][P1_W-1:0]   p1;
        logic [2:0][DMAG_W-1:0] dmag;
        logic [2:0]             dneg;
        logic                   in_seg;
        logic                   take_p1;
        logic [SQ_W-1:0]        nsum;
    } mid_t;

    typedef struct packed {
        logic [2:0][P1_W-1:0] q;
        logic [2:0][PT_W-1:0] nk;
    } fin_t;

    function automatic logic [PT_W-1:0] sat32(input logic signed [CLR_W-1:0] v);
        logic [PT_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[PT_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[PT_W-1:0];
        end else begin
            r = v[PT_W-1:0];
        end
        return r;
    endfunction

    logic en;

    // configuration registers
    logic [CFG_W-1:0] body_radius_reg, head_radius_reg, half_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_radius_reg <= BODY_RADIUS_RST;
            head_radius_reg <= HEAD_RADIUS_RST;
            half_length_reg <= HALF_LENGTH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_BODY_RADIUS: body_radius_reg <= cfg_data;
                CFG_IDX_HEAD_RADIUS: head_radius_reg <= cfg_data;
                CFG_IDX_HALF_LENGTH: half_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: move whenever the output register is free or being taken
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // valid bits
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;
    logic g_valid_reg, h_valid_reg, i_valid_reg, j_valid_reg;
    logic [DIV_STEPS-1:0] div_valid_reg;
    logic [SQ_STEPS-1:0]  sq_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            div_valid_reg <= '0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            j_valid_reg   <= 1'b0;
            sq_valid_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else if (en) begin
            a_valid_reg   <= s_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            div_valid_reg <= {div_valid_reg[DIV_STEPS-2:0], f_valid_reg};
            g_valid_reg   <= div_valid_reg[DIV_STEPS-1];
            h_valid_reg   <= g_valid_reg;
            i_valid_reg   <= h_valid_reg;
            j_valid_reg   <= i_valid_reg;
            sq_valid_reg  <= {sq_valid_reg[SQ_STEPS-2:0], j_valid_reg};
            m_valid_reg   <= sq_valid_reg[SQ_STEPS-1];
        end
    end

    // stage a: input capture
    logic [2:0][PT_W-1:0] pt_a_reg, tor_a_reg, nk_a_reg;
    logic [2:0][AX_W-1:0] ax_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_a_reg  <= {s_point_z, s_point_y, s_point_x};
            tor_a_reg <= {s_torso_z, s_torso_y, s_torso_x};
            ax_a_reg  <= {s_axis_z, s_axis_y, s_axis_x};
            nk_a_reg  <= {s_neck_z, s_neck_y, s_neck_x};
        end
    end

    // stage b: endpoint offsets half_length*|axis|
    logic [2:0][AX_W-1:0]  amag;
    logic [2:0][HLP_W-1:0] hl_prod;
    logic [2:0][OFF_W-1:0] off_next;
    logic [2:0][OFF_W-1:0] off_b_reg;
    logic [2:0]            aneg_b_reg;
    logic [2:0][PT_W-1:0]  pt_b_reg, tor_b_reg, nk_b_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            amag[i]     = ax_a_reg[i][AX_W-1] ? AX_W'(-ax_a_reg[i]) : ax_a_reg[i];
            hl_prod[i]  = HLP_W'(half_length_reg) * HLP_W'(amag[i]);
            off_next[i] = hl_prod[i][FRAC_BITS +: OFF_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            off_b_reg <= off_next;
            for (int i = 0; i < 3; i++) aneg_b_reg[i] <= ax_a_reg[i][AX_W-1];
            pt_b_reg  <= pt_a_reg;
            tor_b_reg <= tor_a_reg;
            nk_b_reg  <= nk_a_reg;
        end
    end

    // stage c: first endpoint, segment direction, point offsets
    logic signed [P1_W-1:0] c_ext [3];
    logic signed [P1_W-1:0] o_ext [3];
    logic signed [P1_W-1:0] p1_next [3];
    logic signed [E_W-1:0]  e_val [3];
    logic signed [HN_W-1:0] hn_val [3];
    logic [2:0][P1_W-1:0]   p1_c_reg;
    logic [2:0][DMAG_W-1:0] dmag_c_reg;
    logic [2:0]             dneg_c_reg, eneg_c_reg;
    logic [2:0][EMAG_W-1:0] emag_c_reg;
    logic [2:0][HMAG_W-1:0] hmag_c_reg;
    logic [2:0][PT_W-1:0]   pt_c_reg, nk_c_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_ext[i]   = P1_W'($signed(tor_b_reg[i]));
            o_ext[i]   = $signed(P1_W'(off_b_reg[i]));
            p1_next[i] = aneg_b_reg[i] ? c_ext[i] - o_ext[i] : c_ext[i] + o_ext[i];
            e_val[i]   = E_W'($signed(pt_b_reg[i])) - E_W'(p1_next[i]);
            hn_val[i]  = HN_W'($signed(pt_b_reg[i])) - HN_W'($signed(nk_b_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p1_c_reg[i]   <= p1_next[i];
                dmag_c_reg[i] <= {off_b_reg[i], 1'b0};
                dneg_c_reg[i] <= !aneg_b_reg[i];
                eneg_c_reg[i] <= e_val[i] < 0;
                emag_c_reg[i] <= (e_val[i] < 0) ? EMAG_W'(-e_val[i]) : EMAG_W'(e_val[i]);
                hmag_c_reg[i] <= (hn_val[i] < 0) ? HMAG_W'(-hn_val[i]) : HMAG_W'(hn_val[i]);
            end
            pt_c_reg <= pt_b_reg;
            nk_c_reg <= nk_b_reg;
        end
    end

    // stage d: products for e.d, d.d and neck distance
    logic [PROD_W-1:0]       prod [3];
    logic signed [NUM_W-1:0] sprod_next [3];
    logic signed [NUM_W-1:0] sprod_d_reg [3];
    logic [2:0][SQD_W-1:0]   sqd_d_reg;
    logic [2:0][NSQ_W-1:0]   nsq_d_reg;
    logic [2:0][PT_W-1:0]    pt_d_reg, nk_d_reg;
    logic [2:0][P1_W-1:0]    p1_d_reg;
    logic [2:0][DMAG_W-1:0]  dmag_d_reg;
    logic [2:0]              dneg_d_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i]       = PROD_W'(emag_c_reg[i]) * PROD_W'(dmag_c_reg[i]);
            sprod_next[i] = (eneg_c_reg[i] != dneg_c_reg[i]) ?
                            -$signed(NUM_W'(prod[i])) : $signed(NUM_W'(prod[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sprod_d_reg[i] <= sprod_next[i];
                sqd_d_reg[i]   <= SQD_W'(dmag_c_reg[i]) * SQD_W'(dmag_c_reg[i]);
                nsq_d_reg[i]   <= NSQ_W'(hmag_c_reg[i]) * NSQ_W'(hmag_c_reg[i]);
            end
            pt_d_reg   <= pt_c_reg;
            nk_d_reg   <= nk_c_reg;
            p1_d_reg   <= p1_c_reg;
            dmag_d_reg <= dmag_c_reg;
            dneg_d_reg <= dneg_c_reg;
        end
    end

    // stage e: sums
    logic signed [NUM_W-1:0] num_e_reg;
    logic [LEN_W-1:0]        len2_e_reg;
    logic [SQ_W-1:0]         nsum_e_reg;
    logic [2:0][PT_W-1:0]    pt_e_reg, nk_e_reg;
    logic [2:0][P1_W-1:0]    p1_e_reg;
    logic [2:0][DMAG_W-1:0]  dmag_e_reg;
    logic [2:0]              dneg_e_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_e_reg  <= sprod_d_reg[0] + sprod_d_reg[1] + sprod_d_reg[2];
            len2_e_reg <= LEN_W'(sqd_d_reg[0]) + LEN_W'(sqd_d_reg[1]) + LEN_W'(sqd_d_reg[2]);
            nsum_e_reg <= SQ_W'(nsq_d_reg[0]) + SQ_W'(nsq_d_reg[1]) + SQ_W'(nsq_d_reg[2]);
            pt_e_reg   <= pt_d_reg;
            nk_e_reg   <= nk_d_reg;
            p1_e_reg   <= p1_d_reg;
            dmag_e_reg <= dmag_d_reg;
            dneg_e_reg <= dneg_d_reg;
        end
    end

    // stage f: projection inside test and endpoint choice (p1 when 2*num < len2)
    logic             inside_next, take_next;
    logic [LEN_W-1:0] num_f_reg, len2_f_reg;
    mid_t             mid_f_reg;

    always_comb begin
        inside_next = (num_e_reg > 0) && (num_e_reg < $signed(NUM_W'(len2_e_reg)));
        take_next   = $signed({num_e_reg, 1'b0}) < $signed((NUM_W+1)'(len2_e_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_f_reg         <= num_e_reg[LEN_W-1:0];
            len2_f_reg        <= len2_e_reg;
            mid_f_reg.pt      <= pt_e_reg;
            mid_f_reg.nk      <= nk_e_reg;
            mid_f_reg.p1      <= p1_e_reg;
            mid_f_reg.dmag    <= dmag_e_reg;
            mid_f_reg.dneg    <= dneg_e_reg;
            mid_f_reg.in_seg  <= inside_next;
            mid_f_reg.take_p1 <= take_next;
            mid_f_reg.nsum    <= nsum_e_reg;
        end
    end

    // projection parameter t = num*2^32/len2
    logic [T_W-1:0] t_quo;

    phc_div_pipe u_div (
        .aclk  (aclk),
        .en    (en),
        .num_i (num_f_reg),
        .den_i (len2_f_reg),
        .quo_o (t_quo)
    );

    mid_t mid_reg [DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg[0] <= mid_f_reg;
            for (int k = 1; k < DIV_STEPS; k++) mid_reg[k] <= mid_reg[k-1];
        end
    end

    // stage g: step along the segment
    logic [SMUL_W-1:0]      smul [3];
    logic [2:0][DMAG_W-1:0] s_g_reg;
    mid_t                   mid_g_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            smul[i] = SMUL_W'(mid_reg[DIV_STEPS-1].dmag[i]) * SMUL_W'(t_quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) s_g_reg[i] <= smul[i][T_W +: DMAG_W];
            mid_g_reg <= mid_reg[DIV_STEPS-1];
        end
    end

    // stage h: nearest torso point and its offset from the query point
    logic signed [P1_W-1:0] p1s [3];
    logic signed [P1_W-1:0] sx [3];
    logic signed [P1_W-1:0] dx [3];
    logic signed [P1_W-1:0] q_next [3];
    logic signed [QD_W-1:0] qd [3];
    logic [2:0][P1_W-1:0]   q_h_reg;
    logic [2:0][QMAG_W-1:0] qmag_h_reg;
    logic [2:0][PT_W-1:0]   nk_h_reg;
    logic [SQ_W-1:0]        nsum_h_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p1s[i] = $signed(mid_g_reg.p1[i]);
            sx[i]  = $signed(P1_W'(s_g_reg[i]));
            dx[i]  = $signed(P1_W'(mid_g_reg.dmag[i]));
            priority if (mid_g_reg.in_seg) begin
                q_next[i] = mid_g_reg.dneg[i] ? p1s[i] - sx[i] : p1s[i] + sx[i];
            end else if (mid_g_reg.take_p1) begin
                q_next[i] = p1s[i];
            end else begin
                q_next[i] = mid_g_reg.dneg[i] ? p1s[i] - dx[i] : p1s[i] + dx[i];
            end
            qd[i] = QD_W'($signed(mid_g_reg.pt[i])) - QD_W'(q_next[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                q_h_reg[i]    <= q_next[i];
                qmag_h_reg[i] <= (qd[i] < 0) ? QMAG_W'(-qd[i]) : QMAG_W'(qd[i]);
            end
            nk_h_reg   <= mid_g_reg.nk;
            nsum_h_reg <= mid_g_reg.nsum;
        end
    end

    // stage i: squares of torso offset
    logic [2:0][QSQ_W-1:0] qsq_i_reg;
    logic [2:0][P1_W-1:0]  q_i_reg;
    logic [2:0][PT_W-1:0]  nk_i_reg;
    logic [SQ_W-1:0]       nsum_i_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                qsq_i_reg[i] <= QSQ_W'(qmag_h_reg[i]) * QSQ_W'(qmag_h_reg[i]);
            end
            q_i_reg    <= q_h_reg;
            nk_i_reg   <= nk_h_reg;
            nsum_i_reg <= nsum_h_reg;
        end
    end

    // stage j: torso squared distance
    logic [SQ_W-1:0] tsum_j_reg, nsum_j_reg;
    fin_t            fin_j_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tsum_j_reg   <= SQ_W'(qsq_i_reg[0]) + SQ_W'(qsq_i_reg[1]) + SQ_W'(qsq_i_reg[2]);
            nsum_j_reg   <= nsum_i_reg;
            fin_j_reg.q  <= q_i_reg;
            fin_j_reg.nk <= nk_i_reg;
        end
    end

    // distances to torso and neck
    logic [ROOT_W-1:0] dist_t, dist_h;

    phc_sqrt_pipe u_sqrt_torso (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (tsum_j_reg),
        .root_o (dist_t)
    );

    phc_sqrt_pipe u_sqrt_head (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (nsum_j_reg),
        .root_o (dist_h)
    );

    fin_t fin_reg [SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg[0] <= fin_j_reg;
            for (int k = 1; k < SQ_STEPS; k++) fin_reg[k] <= fin_reg[k-1];
        end
    end

    // output stage: pick smaller clearance, torso wins a tie
    logic signed [CLR_W-1:0] clr_t, clr_h;
    logic                    head_next;
    logic [PT_W-1:0]         m_clearance_reg;
    logic                    m_head_nearest_reg;
    logic [2:0][PT_W-1:0]    m_nearest_reg;

    always_comb begin
        clr_t     = $signed(CLR_W'(dist_t)) - $signed(CLR_W'(body_radius_reg));
        clr_h     = $signed(CLR_W'(dist_h)) - $signed(CLR_W'(head_radius_reg));
        head_next = clr_h < clr_t;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_clearance_reg    <= sat32(head_next ? clr_h : clr_t);
            m_head_nearest_reg <= head_next;
            for (int i = 0; i < 3; i++) begin
                m_nearest_reg[i] <= head_next ? fin_reg[SQ_STEPS-1].nk[i] :
                                    sat32(CLR_W'($signed(fin_reg[SQ_STEPS-1].q[i])));
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_clearance    = $signed(m_clearance_reg);
    assign m_head_nearest = m_head_nearest_reg;
    assign m_nearest_x    = $signed(m_nearest_reg[0]);
    assign m_nearest_y    = $signed(m_nearest_reg[1]);
    assign m_nearest_z    = $signed(m_nearest_reg[2]);

endmodule
